@@ src/plist_pkg.sv @@
// ----------------------------------------------------------------------------
// plist_pkg: shared types and constants of the positional list store
// Beat formats, operation and status codes, per-cell shift commands.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

  localparam int DefCapacity = 32;
  localparam int DataW       = 32;
  localparam int EntriesW    = 6;

  typedef enum logic [2:0] {
    MODE_INS_FIRST = 3'd0,
    MODE_INS_LAST  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FIRST = 3'd3,
    MODE_DEL_LAST  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_DUMP      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_LOAD  = 3'd1,
    CELL_LEFT  = 3'd2,
    CELL_RIGHT = 3'd3,
    CELL_HEAD  = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic [2:0]              mode;
    logic [7:0]              position;
    logic signed [DataW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] element;
    logic                    last_flag;
    logic [EntriesW-1:0]     entries;
  } out_beat_t;

endpackage

`default_nettype wire

@@ src/plist_cell.sv @@
// ----------------------------------------------------------------------------
// plist_cell: one slot of the list
// Holds one entry; loads the new value, or takes a neighbor's or the head slot's entry on command.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_cell (
  input  wire logic                              clk_i,
  input  wire plist_pkg::cell_op_e               op_i,
  input  wire logic signed [plist_pkg::DataW-1:0] value_i,
  input  wire logic signed [plist_pkg::DataW-1:0] left_i,
  input  wire logic signed [plist_pkg::DataW-1:0] right_i,
  input  wire logic signed [plist_pkg::DataW-1:0] head_i,
  output logic signed [plist_pkg::DataW-1:0]      slot_o
);
  import plist_pkg::*;

  logic signed [DataW-1:0] slot_d, slot_q;

  always_comb begin
    case (op_i)
      CELL_LOAD:  slot_d = value_i;
      CELL_LEFT:  slot_d = left_i;
      CELL_RIGHT: slot_d = right_i;
      CELL_HEAD:  slot_d = head_i;
      default:    slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ src/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list of signed 32-bit entries
// A row of slot cells plus an entry count; inserts and deletes shift the row
// by one place, a dump rotates the occupied cells through the head slot.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | beat
//  in      | input     | in_valid_i/in_ready_o   | in_beat_t  (mode, position, value)
//  out     | output    | out_valid_o/out_ready_i | out_beat_t (status, element, last, entries)
//
//  Insert, delete, bad request: one result beat, which is registered.
//  Dump of n entries: n beats, one rotation of the cell row per beat.
//  No new beat is taken while a dump is in progress.
//  Reset clears the count and control; slot contents are don't-care.
//  A stalled output holds the row, the dump resumes when the beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = plist_pkg::DefCapacity
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire plist_pkg::in_beat_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output plist_pkg::out_beat_t      out_data_o
);
  import plist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q, out_d;

  logic          out_free, accept, emit;
  logic          do_ins, do_del, do_rot, start_dump;
  logic [CW-1:0] idx;
  status_e       status;
  logic [8:0]    pos9, cnt9;

  cell_op_e                cell_op [CAPACITY];
  logic signed [DataW-1:0] slot    [CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == ST_DUMP) && out_free;
  assign do_rot     = emit;

  assign pos9 = {1'b0, in_data_i.position};
  assign cnt9 = 9'(count_q);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    start_dump = 1'b0;
    idx        = '0;
    status     = STAT_OK;
    case (mode_e'(in_data_i.mode))
      MODE_INS_FIRST, MODE_INS_LAST: begin
        if (count_q >= CW'(CAPACITY)) begin
          status = STAT_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = (in_data_i.mode == MODE_INS_FIRST) ? '0 : count_q;
        end
      end
      MODE_INS_POS: begin
        if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
          status = STAT_BADPOS;
        end else if (count_q >= CW'(CAPACITY)) begin
          status = STAT_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = CW'(pos9 - 9'd1);
        end
      end
      MODE_DEL_FIRST, MODE_DEL_LAST: begin
        if (count_q == '0) begin
          status = STAT_EMPTY;
        end else begin
          do_del = 1'b1;
          idx    = (in_data_i.mode == MODE_DEL_FIRST) ? '0 : count_q - CW'(1);
        end
      end
      MODE_DEL_POS: begin
        if (pos9 == 9'd0 || pos9 > cnt9) begin
          status = STAT_BADPOS;
        end else begin
          do_del = 1'b1;
          idx    = CW'(pos9 - 9'd1);
        end
      end
      MODE_DUMP: begin
        if (count_q == '0) begin
          status = STAT_EMPTY;
        end else begin
          start_dump = 1'b1;
        end
      end
      default: status = STAT_OK;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = slot[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (do_rot) begin
        if (CW'(i + 1) < count_q) begin
          cell_op[i] = CELL_RIGHT;
        end else if (CW'(i + 1) == count_q) begin
          cell_op[i] = CELL_HEAD;
        end
      end else if (accept && do_ins) begin
        if (CW'(i) == idx) begin
          cell_op[i] = CELL_LOAD;
        end else if (CW'(i) > idx) begin
          cell_op[i] = CELL_LEFT;
        end
      end else if (accept && do_del) begin
        if (CW'(i) >= idx) begin
          cell_op[i] = CELL_RIGHT;
        end
      end
    end

    plist_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .value_i (in_data_i.value),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (slot[0]),
      .slot_o  (slot[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (accept) begin
      if (do_ins) begin
        count_d = count_q + CW'(1);
      end else if (do_del) begin
        count_d = count_q - CW'(1);
      end
      if (start_dump) begin
        state_d = ST_DUMP;
        rem_d   = count_q;
      end else begin
        out_valid_d     = 1'b1;
        out_d.status    = status;
        out_d.element   = '0;
        out_d.last_flag = 1'b1;
        out_d.entries   = EntriesW'(count_d);
      end
    end else if (emit) begin
      out_valid_d     = 1'b1;
      out_d.status    = STAT_OK;
      out_d.element   = slot[0];
      out_d.last_flag = (rem_q == CW'(1));
      out_d.entries   = EntriesW'(count_q);
      rem_d           = rem_q - CW'(1);
      if (rem_q == CW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |=> count_q == $past(count_q))
    else $error("count changed during dump");

  a_fault_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_OK |-> out_data_o.last_flag)
    else $error("fault beat without last flag");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && rem_q == CW'(1) |=> state_q == ST_IDLE && out_valid_o && out_data_o.last_flag)
    else $error("dump did not close with last beat");

  a_dump_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> rem_q != '0 && rem_q <= count_q)
    else $error("dump remainder out of range");

endmodule

`default_nettype wire

@@ sim/plist_checker.sv @@
// ----------------------------------------------------------------------------
// plist_checker: scoreboard for the positional list store
// Watches both channels. It keeps a shadow copy of the list, works out the
// beats that each accepted operation must produce, and compares every
// output beat field by field with the oldest beat still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_checker #(
  parameter int CAPACITY = plist_pkg::DefCapacity
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire plist_pkg::in_beat_t  in_beat_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire plist_pkg::out_beat_t out_beat_i,
  output int                        mismatches_o,
  output int                        outstanding_o
);

  import plist_pkg::*;

  logic signed [DataW-1:0] shadow_slots [CAPACITY];
  int                      shadow_count;
  out_beat_t               awaited_beats [$];

  function automatic out_beat_t make_result(status_e st, logic signed [DataW-1:0] elem,
                                            logic last);
    out_beat_t r;
    r.status    = st;
    r.element   = elem;
    r.last_flag = last;
    r.entries   = EntriesW'(shadow_count);
    return r;
  endfunction

  // Applies one operation to the shadow list and queues the beats it causes.
  task automatic apply_op(in_beat_t b);
    status_e st;
    int      idx;
    int      i;
    st = STAT_OK;
    case (b.mode)
      MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_POS: begin
        if (b.mode == MODE_INS_FIRST) idx = 0;
        else if (b.mode == MODE_INS_LAST) idx = shadow_count;
        else idx = int'(b.position) - 1;
        if (b.mode == MODE_INS_POS && (b.position == 0 || b.position > shadow_count + 1)) begin
          st = STAT_BADPOS;
        end else if (shadow_count >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          for (i = shadow_count; i > idx; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[idx] = b.value;
          shadow_count++;
        end
      end
      MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_POS: begin
        if (b.mode == MODE_DEL_FIRST) idx = 0;
        else if (b.mode == MODE_DEL_LAST) idx = shadow_count - 1;
        else idx = int'(b.position) - 1;
        if (b.mode == MODE_DEL_POS && (b.position == 0 || b.position > shadow_count)) begin
          st = STAT_BADPOS;
        end else if (shadow_count == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_count--;
        end
      end
      MODE_DUMP: begin
        if (shadow_count == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            awaited_beats.push_back(make_result(STAT_OK, shadow_slots[i],
                                                i + 1 == shadow_count));
          end
          return;
        end
      end
      default: ;
    endcase
    awaited_beats.push_back(make_result(st, '0, 1'b1));
  endtask

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    logic      bad;
    if (awaited_beats.size() == 0) begin
      $display("%0t unexpected beat: expected none, got %p", $time, got);
      mismatches_o++;
      return;
    end
    want = awaited_beats.pop_front();
    bad  = 1'b0;
    if (got.status !== want.status) begin
      bad = 1'b1;
      $display("%0t status: expected %0d, got %0d", $time, want.status, got.status);
    end
    if (got.element !== want.element) begin
      bad = 1'b1;
      $display("%0t element: expected %0d, got %0d", $time, want.element, got.element);
    end
    if (got.last_flag !== want.last_flag) begin
      bad = 1'b1;
      $display("%0t last_flag: expected %0b, got %0b", $time, want.last_flag,
               got.last_flag);
    end
    if (got.entries !== want.entries) begin
      bad = 1'b1;
      $display("%0t entries: expected %0d, got %0d", $time, want.entries, got.entries);
    end
    if (bad) mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_beats.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_beat(out_beat_i);
      if (in_valid_i && in_ready_i) apply_op(in_beat_i);
      outstanding_o <= awaited_beats.size();
    end
  end

endmodule

`default_nettype wire

@@ sim/positional_list_store_test.sv @@
// ----------------------------------------------------------------------------
// positional_list_store_test: top level testbench of the positional list store
// Drives directed corner operations, a drain and a fill past capacity, and biased
// random operation bursts under three idling patterns; plist_checker does
// the prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_test;

  import plist_pkg::*;

  localparam int         Capacity   = DefCapacity;
  localparam int         CycleLimit = 400000;
  localparam int         TailCycles = 40;
  localparam int         BurstLen   = 18;
  localparam logic [2:0] ModeUnused = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_beat_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  positional_list_store #(.CAPACITY(Capacity)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  plist_checker #(.CAPACITY(Capacity)) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_beat_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_i   (out_data_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_beat_t mk_beat(logic [2:0] mode, logic [7:0] pos, logic [31:0] val);
    in_beat_t b;
    b.mode     = mode;
    b.position = pos;
    b.value    = val;
    return b;
  endfunction

  // grow_pct sets the share of inserts; deletes take most of the rest.
  function automatic in_beat_t pick_beat(int grow_pct);
    in_beat_t b;
    int       r;
    r = $urandom_range(99);
    if (r < grow_pct) begin
      case ($urandom_range(2))
        0:       b.mode = MODE_INS_FIRST;
        1:       b.mode = MODE_INS_LAST;
        default: b.mode = MODE_INS_POS;
      endcase
    end else if (r < 92) begin
      case ($urandom_range(2))
        0:       b.mode = MODE_DEL_FIRST;
        1:       b.mode = MODE_DEL_LAST;
        default: b.mode = MODE_DEL_POS;
      endcase
    end else if (r < 98) begin
      b.mode = MODE_DUMP;
    end else begin
      b.mode = ModeUnused;
    end
    b.position = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(Capacity + 2));
    b.value    = $urandom;
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_bursts(int bursts);
    int n;
    int k;
    int grow;
    for (n = 0; n < bursts; n++) begin
      grow = $urandom_range(1) ? 70 : 25;
      for (k = 0; k < BurstLen; k++) send_beat(pick_beat(grow));
    end
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 15;
    rx_idle_pct <= 45;

    // empty list corners
    send_beat(mk_beat(MODE_DUMP, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_FIRST, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_LAST, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_POS, 8'd1, 32'd0));
    send_beat(mk_beat(MODE_INS_POS, 8'd0, 32'h1234_5678));
    send_beat(mk_beat(MODE_INS_POS, 8'd2, 32'h1234_5678));
    send_beat(mk_beat(ModeUnused, 8'd3, 32'hdead_beef));
    // value extremes and position bounds
    send_beat(mk_beat(MODE_INS_FIRST, 8'd0, 32'h7fff_ffff));
    send_beat(mk_beat(MODE_INS_LAST, 8'd0, 32'h8000_0000));
    send_beat(mk_beat(MODE_INS_POS, 8'd2, 32'h0000_0000));
    send_beat(mk_beat(MODE_INS_POS, 8'd4, 32'hffff_ffff));
    send_beat(mk_beat(MODE_INS_POS, 8'd6, 32'h0000_0001));
    send_beat(mk_beat(MODE_DEL_POS, 8'd5, 32'd0));
    send_beat(mk_beat(MODE_DEL_POS, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DUMP, 8'd255, 32'd0));
    send_beat(mk_beat(MODE_INS_POS, 8'd255, 32'h5a5a_5a5a));
    send_beat(mk_beat(MODE_DEL_POS, 8'd2, 32'd0));
    send_beat(mk_beat(MODE_DEL_FIRST, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_LAST, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DUMP, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_POS, 8'd1, 32'd0));
    send_beat(mk_beat(MODE_INS_POS, 8'd1, 32'd1));

    run_bursts(4);
    wait_drained();

    tx_idle_pct = 45;
    rx_idle_pct <= 15;

    // empty, fill past capacity, then the full list corners
    for (i = 0; i < Capacity + 2; i++) send_beat(mk_beat(MODE_DEL_LAST, 8'd0, 32'd0));
    for (i = 0; i < Capacity + 2; i++) send_beat(mk_beat(MODE_INS_LAST, 8'd0, $urandom));
    send_beat(mk_beat(MODE_INS_FIRST, 8'd0, $urandom));
    send_beat(mk_beat(MODE_INS_POS, 8'(Capacity + 1), $urandom));
    send_beat(mk_beat(MODE_INS_POS, 8'(Capacity + 2), $urandom));
    send_beat(mk_beat(MODE_INS_POS, 8'd1, $urandom));
    send_beat(mk_beat(MODE_DEL_POS, 8'(Capacity + 1), 32'd0));
    send_beat(mk_beat(MODE_DUMP, 8'd0, 32'd0));
    send_beat(mk_beat(MODE_DEL_POS, 8'(Capacity), 32'd0));
    send_beat(mk_beat(MODE_INS_POS, 8'(Capacity), $urandom));
    send_beat(mk_beat(MODE_DUMP, 8'd0, 32'd0));

    run_bursts(3);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_bursts(2);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
